[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker of this block.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FMRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an expression never holds outside reset.
`define FMRF_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[hdl/fmrf_pkg.sv]
// Package of the framed message ring FIFO: sizes, field layout and codes.
// Used by the top level and its checker; no dependencies.
package fmrf_pkg;

  localparam int BUF_BYTES   = 4096;
  localparam int ADDR_W      = $clog2(BUF_BYTES);
  localparam int PTR_W       = ADDR_W + 1;
  localparam int MAX_PAYLOAD = 63;
  localparam int HDR_BYTES   = 8;
  localparam int LEN_W       = 6;
  localparam int USED_W      = 13;

  localparam int S_TDATA_W   = 48;
  localparam int RES_BITS    = 2 + 32 + LEN_W + 8 + USED_W;
  localparam int M_TDATA_W   = 64;
  localparam int USED_LSB    = 2 + 32 + LEN_W + 8;
  localparam int OLEN_LSB    = 2 + 32;

  typedef enum logic [1:0] {
    CMD_PUSH_BEGIN = 2'd0,
    CMD_PUSH_BYTE  = 2'd1,
    CMD_POP        = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BUSY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic [31:0]        addr;
    logic [LEN_W-1:0]   len;
    logic [7:0]         data;
    logic               last;
    logic [USED_W-1:0]  used;
  } res_t;

endpackage

[hdl/fmrf_ram.sv]
// Simple dual-port byte store: one write port, one read port, registered read.
// Generic; no package dependency.
module fmrf_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[hdl/framed_message_ring_fifo.sv]
// Top level of the framed message ring FIFO: command decode, sequencer, result register.
// Depends on fmrf_pkg and fmrf_ram.

// Messages (8-byte header: address then length, low byte first, then payload) are
// kept in a 4096-byte ring memory with one write and one read port. A push payload
// byte, a clear and every refused command leave the sequencer in idle; an accepted
// push begin then writes its 8 header bytes through the write port one per cycle.
// An accepted pop reads the 8 header bytes through the registered read port, emits
// the header result, then reads the payload through the read port and gives one
// payload byte per cycle, slower while the result side stalls. Each command that
// is not an accepted pop gives one status result. No clearing pass follows reset;
// the ring starts empty.
module framed_message_ring_fifo import fmrf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // msg_addr[31:0], msg_len[37:32], data_byte[45:38], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // cmd[1:0]
  input  logic [1:0]           s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // status[1:0], out_addr[33:2], out_len[39:34], out_byte[47:40],
  // used_bytes[60:48], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // kind[1:0]
  output logic [1:0]           m_axis_tuser_o,
  output logic                 m_axis_tlast_o
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_HDR_WR  = 5'b00010,
    S_POP_HDR = 5'b00100,
    S_POP_LEN = 5'b01000,
    S_POP_DAT = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [PTR_W-1:0]   rp_q, rp_d, wp_q, wp_d;
  logic               open_q, open_d;
  logic [LEN_W-1:0]   left_q, left_d;
  logic [2:0]         hw_idx_q, hw_idx_d;
  logic [LEN_W-1:0]   iss_left_q, iss_left_d;
  logic [LEN_W-1:0]   out_left_q, out_left_d;
  logic               dv_q, dv_d;
  logic [63:0]        hdr_q, hdr_d;
  logic [PTR_W-1:0]   pop_used_q, pop_used_d;
  logic [31:0]        maddr_q, maddr_d;
  logic [LEN_W-1:0]   mlen_q, mlen_d;
  logic [PTR_W-1:0]   after_q, after_d;
  logic [31:0]        pa_q, pa_d;
  logic [LEN_W-1:0]   plen_q, plen_d;
  logic               m_valid_q;
  res_t               out_q;

  logic               out_free, in_acc, emit, consume, issue, room;
  res_t               res;
  cmd_e               in_cmd;
  logic [31:0]        in_addr;
  logic [LEN_W-1:0]   in_len;
  logic [7:0]         in_data;
  logic [PTR_W-1:0]   used_now, lim;
  logic [PTR_W:0]     need;
  logic [31:0]        len_word, m32;
  logic [LEN_W-1:0]   mlen_c;
  logic [63:0]        hdr_word;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [7:0]         mem_wdata, mem_rdata;

  assign in_cmd   = cmd_e'(s_axis_tuser_i);
  assign in_addr  = s_axis_tdata_i[31:0];
  assign in_len   = s_axis_tdata_i[32 +: LEN_W];
  assign in_data  = s_axis_tdata_i[32 + LEN_W +: 8];

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign used_now = wp_q - rp_q;
  assign need     = (PTR_W+1)'(used_now) + (PTR_W+1)'(in_len) + (PTR_W+1)'(HDR_BYTES);
  assign room     = (need <= (PTR_W+1)'(BUF_BYTES)) && (in_len <= LEN_W'(MAX_PAYLOAD));
  assign hdr_word = {{(32-LEN_W){1'b0}}, plen_q, pa_q};

  // clamp the stored length to what the ring and the payload limit allow
  assign len_word = hdr_q[63:32];
  assign lim      = pop_used_q - PTR_W'(HDR_BYTES);
  assign m32      = (len_word > 32'(lim)) ? 32'(lim) : len_word;
  assign mlen_c   = (m32 > 32'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : m32[LEN_W-1:0];

  always_comb begin
    state_d    = state_q;
    rp_d       = rp_q;
    wp_d       = wp_q;
    open_d     = open_q;
    left_d     = left_q;
    hw_idx_d   = hw_idx_q;
    iss_left_d = iss_left_q;
    out_left_d = out_left_q;
    dv_d       = dv_q;
    hdr_d      = hdr_q;
    pop_used_d = pop_used_q;
    maddr_d    = maddr_q;
    mlen_d     = mlen_q;
    after_d    = after_q;
    pa_d       = pa_q;
    plen_d     = plen_q;
    emit       = 1'b0;
    consume    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = wp_q[ADDR_W-1:0];
    mem_wdata  = in_data;
    mem_re     = 1'b0;
    mem_raddr  = rp_q[ADDR_W-1:0];
    res.kind   = KIND_STATUS;
    res.status = ST_OK;
    res.addr   = '0;
    res.len    = '0;
    res.data   = '0;
    res.last   = 1'b1;
    res.used   = USED_W'(used_now);

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          emit = 1'b1;
          case (in_cmd)
            CMD_PUSH_BEGIN: begin
              if (open_q) begin
                res.status = ST_BUSY;
              end else if (!room) begin
                res.status = ST_NO_SPACE;
              end else begin
                pa_d     = in_addr;
                plen_d   = in_len;
                hw_idx_d = '0;
                open_d   = (in_len != '0);
                left_d   = in_len;
                state_d  = S_HDR_WR;
                res.used = USED_W'(used_now + PTR_W'(HDR_BYTES));
              end
            end
            CMD_PUSH_BYTE: begin
              if (!open_q || left_q == '0) begin
                open_d     = 1'b0;
                res.status = ST_BUSY;
              end else begin
                mem_we   = 1'b1;
                wp_d     = wp_q + 1'b1;
                left_d   = left_q - 1'b1;
                open_d   = (left_q != LEN_W'(1));
                res.used = USED_W'(used_now + 1'b1);
              end
            end
            CMD_POP: begin
              if (open_q) begin
                res.status = ST_BUSY;
              end else if (used_now < PTR_W'(HDR_BYTES)) begin
                res.status = ST_EMPTY;
              end else begin
                emit       = 1'b0;
                pop_used_d = used_now;
                iss_left_d = LEN_W'(HDR_BYTES);
                out_left_d = LEN_W'(HDR_BYTES);
                state_d    = S_POP_HDR;
              end
            end
            CMD_CLEAR: begin
              rp_d     = '0;
              wp_d     = '0;
              open_d   = 1'b0;
              left_d   = '0;
              res.used = '0;
            end
            default: begin
              res.status = ST_BUSY;
            end
          endcase
        end
      end
      S_HDR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = hdr_word[hw_idx_q*8 +: 8];
        wp_d      = wp_q + 1'b1;
        hw_idx_d  = hw_idx_q + 1'b1;
        if (hw_idx_q == 3'd7) begin
          state_d = S_IDLE;
        end
      end
      S_POP_HDR: begin
        consume = dv_q;
        if (consume) begin
          hdr_d      = {mem_rdata, hdr_q[63:8]};
          out_left_d = out_left_q - 1'b1;
          if (out_left_q == LEN_W'(1)) begin
            state_d = S_POP_LEN;
          end
        end
      end
      S_POP_LEN: begin
        if (out_free) begin
          emit       = 1'b1;
          res.kind   = KIND_HEADER;
          res.addr   = hdr_q[31:0];
          res.len    = mlen_c;
          res.last   = (mlen_c == '0);
          res.used   = USED_W'(lim - PTR_W'(mlen_c));
          maddr_d    = hdr_q[31:0];
          mlen_d     = mlen_c;
          after_d    = lim - PTR_W'(mlen_c);
          iss_left_d = mlen_c;
          out_left_d = mlen_c;
          state_d    = (mlen_c == '0) ? S_IDLE : S_POP_DAT;
        end
      end
      S_POP_DAT: begin
        consume = dv_q && out_free;
        if (consume) begin
          emit       = 1'b1;
          res.kind   = KIND_PAYLOAD;
          res.addr   = maddr_q;
          res.len    = mlen_q;
          res.data   = mem_rdata;
          res.last   = (out_left_q == LEN_W'(1));
          res.used   = USED_W'(after_q);
          out_left_d = out_left_q - 1'b1;
          if (out_left_q == LEN_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // fetch the next byte once the held read word is free
    issue = ((state_q == S_POP_HDR) || (state_q == S_POP_DAT)) &&
            (iss_left_q != '0) && (!dv_q || consume);
    if (issue) begin
      mem_re     = 1'b1;
      rp_d       = rp_q + 1'b1;
      iss_left_d = iss_left_q - 1'b1;
      dv_d       = 1'b1;
    end else if (consume) begin
      dv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rp_q       <= '0;
      wp_q       <= '0;
      open_q     <= 1'b0;
      left_q     <= '0;
      hw_idx_q   <= '0;
      iss_left_q <= '0;
      out_left_q <= '0;
      dv_q       <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rp_q       <= rp_d;
      wp_q       <= wp_d;
      open_q     <= open_d;
      left_q     <= left_d;
      hw_idx_q   <= hw_idx_d;
      iss_left_q <= iss_left_d;
      out_left_q <= out_left_d;
      dv_q       <= dv_d;
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q      <= hdr_d;
    pop_used_q <= pop_used_d;
    maddr_q    <= maddr_d;
    mlen_q     <= mlen_d;
    after_q    <= after_d;
    pa_q       <= pa_d;
    plen_q     <= plen_d;
    if (emit) begin
      out_q <= res;
    end
  end

  fmrf_ram #(
    .DEPTH (BUF_BYTES),
    .WIDTH (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {{(M_TDATA_W-RES_BITS){1'b0}}, out_q.used, out_q.data,
                            out_q.len, out_q.addr, out_q.status};

endmodule

[hdl/fmrf_checker.sv]
// Port-level checker for the framed message ring FIFO, bound to the top level.
// Depends on fmrf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fmrf_checker import fmrf_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input logic [1:0]           s_axis_tuser_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]           m_axis_tuser_o,
  input logic                 m_axis_tlast_o
);

  logic [USED_W-1:0] used_w;
  logic [LEN_W-1:0]  len_w;
  logic [1:0]        status_w;
  logic              unused_in;

  assign used_w    = m_axis_tdata_o[USED_LSB +: USED_W];
  assign len_w     = m_axis_tdata_o[OLEN_LSB +: LEN_W];
  assign status_w  = m_axis_tdata_o[1:0];
  assign unused_in = s_axis_tvalid_i & s_axis_tready_o & (|s_axis_tdata_i) & (|s_axis_tuser_i);

  `FMRF_ASSERT(a_hold_stalled, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "stalled result changed")
  `FMRF_ASSERT(a_status_last, m_axis_tvalid_o && m_axis_tuser_o == KIND_STATUS |-> m_axis_tlast_o, "status result not marked last")
  `FMRF_ASSERT(a_empty_hdr_last, m_axis_tvalid_o && m_axis_tuser_o == KIND_HEADER && len_w == '0 |-> m_axis_tlast_o, "header of empty message not last")
  `FMRF_ASSERT(a_pop_ok, m_axis_tvalid_o && m_axis_tuser_o != KIND_STATUS |-> status_w == ST_OK, "popped result with bad status")
  `FMRF_ASSERT_NEVER(a_used_range, m_axis_tvalid_o && (used_w > USED_W'(BUF_BYTES)), "used bytes beyond ring size")

endmodule

bind framed_message_ring_fifo fmrf_checker u_fmrf_checker (.*);

[sim/framed_message_checker.sv]
// Checker for the framed message ring FIFO: watches both stream ports, predicts every result.
// Holds its own copy of the ring, pointers and push state; depends on fmrf_pkg.
module framed_message_checker import fmrf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic [1:0]           s_tuser_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [M_TDATA_W-1:0] m_tdata_i,
  input  logic [1:0]           m_tuser_i,
  input  logic                 m_tlast_i,
  output int                   mismatch_count_o,
  output int                   pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]       ring_bytes [BUF_BYTES];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic             push_open;
  logic [LEN_W-1:0] bytes_left;
  res_t             pending_results [$];
  int               mismatch_count = 0;

  // Pointers run modulo twice the ring size, so the difference is the fill level.
  function automatic logic [USED_W-1:0] fill_level();
    return USED_W'(wr_ptr - rd_ptr);
  endfunction

  function automatic void store_byte(logic [7:0] b);
    ring_bytes[wr_ptr[ADDR_W-1:0]] = b;
    wr_ptr = wr_ptr + 1'b1;
  endfunction

  function automatic logic [7:0] fetch_byte();
    logic [7:0] b;
    b = ring_bytes[rd_ptr[ADDR_W-1:0]];
    rd_ptr = rd_ptr + 1'b1;
    return b;
  endfunction

  function automatic void store_word(logic [31:0] w);
    store_byte(w[7:0]);
    store_byte(w[15:8]);
    store_byte(w[23:16]);
    store_byte(w[31:24]);
  endfunction

  function automatic logic [31:0] fetch_word();
    logic [31:0] w;
    w[7:0]   = fetch_byte();
    w[15:8]  = fetch_byte();
    w[23:16] = fetch_byte();
    w[31:24] = fetch_byte();
    return w;
  endfunction

  // Advance the ring state by one command and queue the results it causes.
  function automatic void apply_command(cmd_e cmd, logic [31:0] addr, logic [LEN_W-1:0] len,
                                        logic [7:0] data);
    res_t        batch [$];
    res_t        r;
    int unsigned free_bytes;
    int unsigned held;
    int unsigned n;
    logic [31:0] tag;
    r = '0;
    r.kind   = KIND_STATUS;
    r.status = ST_OK;
    r.last   = 1'b1;
    case (cmd)
      CMD_PUSH_BEGIN: begin
        free_bytes = BUF_BYTES - 32'(fill_level());
        if (push_open) begin
          r.status = ST_BUSY;
        end else if (len > MAX_PAYLOAD || free_bytes < 32'(len) + HDR_BYTES) begin
          r.status = ST_NO_SPACE;
        end else begin
          store_word(addr);
          store_word({26'd0, len});
          push_open  = (len != '0);
          bytes_left = len;
        end
        batch.push_back(r);
      end
      CMD_PUSH_BYTE: begin
        if (!push_open || bytes_left == '0) begin
          push_open = 1'b0;
          r.status  = ST_BUSY;
        end else begin
          store_byte(data);
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == '0) push_open = 1'b0;
        end
        batch.push_back(r);
      end
      CMD_POP: begin
        held = 32'(fill_level());
        if (push_open) begin
          r.status = ST_BUSY;
          batch.push_back(r);
        end else if (held < HDR_BYTES) begin
          r.status = ST_EMPTY;
          batch.push_back(r);
        end else begin
          tag = fetch_word();
          n   = fetch_word();
          // Clamp a stored length that the held bytes cannot back.
          if (n > held - HDR_BYTES) n = held - HDR_BYTES;
          if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
          r.kind = KIND_HEADER;
          r.addr = tag;
          r.len  = n[LEN_W-1:0];
          r.last = (n == 0);
          batch.push_back(r);
          r.kind = KIND_PAYLOAD;
          for (int i = 0; i < n; i++) begin
            r.data = fetch_byte();
            r.last = (i == n - 1);
            batch.push_back(r);
          end
        end
      end
      default: begin
        rd_ptr     = '0;
        wr_ptr     = '0;
        push_open  = 1'b0;
        bytes_left = '0;
        batch.push_back(r);
      end
    endcase
    foreach (batch[i]) begin
      batch[i].used = fill_level();
      pending_results.push_back(batch[i]);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_result();
    res_t want;
    if (pending_results.size() == 0) begin
      $error("result transfer with nothing expected: tuser %0h tdata %0h", m_tuser_i, m_tdata_i);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    check_field("kind", 32'(want.kind), 32'(m_tuser_i));
    check_field("status", 32'(want.status), 32'(m_tdata_i[1:0]));
    check_field("out_addr", want.addr, m_tdata_i[33:2]);
    check_field("out_len", 32'(want.len), 32'(m_tdata_i[OLEN_LSB +: LEN_W]));
    check_field("out_byte", 32'(want.data), 32'(m_tdata_i[OLEN_LSB+LEN_W +: 8]));
    check_field("last", 32'(want.last), 32'(m_tlast_i));
    check_field("used_bytes", 32'(want.used), 32'(m_tdata_i[USED_LSB +: USED_W]));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr     = '0;
      wr_ptr     = '0;
      push_open  = 1'b0;
      bytes_left = '0;
      pending_results.delete();
      pending_count_o  <= 0;
      mismatch_count_o <= mismatch_count;
    end else begin
      // Retire first so a stray result is never matched to a command of this edge.
      if (m_tvalid_i && m_tready_i) check_result();
      if (s_tvalid_i && s_tready_i) begin
        apply_command(cmd_e'(s_tuser_i), s_tdata_i[31:0], s_tdata_i[37:32], s_tdata_i[45:38]);
      end
      pending_count_o  <= pending_results.size();
      mismatch_count_o <= mismatch_count;
    end
  end

endmodule

[sim/testbench.sv]
// Top of the framed message ring FIFO testbench: clock, reset, command stimulus and verdict.
// Instantiates framed_message_ring_fifo and framed_message_checker; depends on fmrf_pkg.
module testbench import fmrf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [S_TDATA_W-1:0] s_data = '0;
  logic [1:0]           s_user = '0;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_data;
  logic [1:0]           m_user;
  logic                 m_last;
  int                   mismatches;
  int                   pending;
  int                   cycle_count = 0;
  int                   burst_left = 0;
  int                   items_sent = 0;
  int                   hold_requests = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  framed_message_ring_fifo dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  framed_message_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_tvalid_i       (s_valid),
    .s_tready_i       (s_ready),
    .s_tdata_i        (s_data),
    .s_tuser_i        (s_user),
    .m_tvalid_i       (m_valid),
    .m_tready_i       (m_ready),
    .m_tdata_i        (m_data),
    .m_tuser_i        (m_user),
    .m_tlast_i        (m_last),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one command and hold it until the transfer; bursts are broken by random gaps.
  task automatic send_item(cmd_e cmd, logic [31:0] addr, logic [LEN_W-1:0] len,
                           logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= {2'b00, data, len, addr};
    s_user  <= cmd;
    do @(posedge clk); while (!s_ready);
    items_sent++;
  endtask

  task automatic push_begin(logic [31:0] addr, logic [LEN_W-1:0] len);
    send_item(CMD_PUSH_BEGIN, addr, len, 8'($urandom()));
  endtask

  task automatic push_byte(logic [7:0] data);
    send_item(CMD_PUSH_BYTE, $urandom(), LEN_W'($urandom()), data);
  endtask

  task automatic pop_message();
    send_item(CMD_POP, $urandom(), LEN_W'($urandom()), 8'($urandom()));
  endtask

  task automatic clear_ring();
    send_item(CMD_CLEAR, $urandom(), LEN_W'($urandom()), 8'($urandom()));
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return LEN_W'($urandom_range(0, 7));
    if (pick < 9) return LEN_W'($urandom_range(8, 31));
    return ($urandom_range(0, 1) == 0) ? 6'd63 : LEN_W'($urandom_range(32, 63));
  endfunction

  // Well-formed push with random content; now and then a command cuts in while it is open.
  task automatic send_message(logic [LEN_W-1:0] len);
    push_begin($urandom(), len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 0) pop_message();
        else push_begin($urandom(), pick_len());
      end
      push_byte(8'($urandom()));
    end
  endtask

  // Receiver: runs of its own stall pattern, plus a long hold-off on request.
  initial begin
    int run;
    int mode;
    int holds_done;
    holds_done = 0;
    wait (rst_n);
    forever begin
      if (holds_done < hold_requests) begin
        holds_done++;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      run  = $urandom_range(8, 64);
      repeat (run) begin
        case (mode)
          0: m_ready <= 1'b1;
          1: m_ready <= ($urandom_range(0, 3) != 0);
          2: m_ready <= ($urandom_range(0, 3) == 0);
          default: m_ready <= ~m_ready;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int random_start;
    int pick;
    int len;
    bit mid_hold;
    mid_hold = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pop, stray byte, extreme tags, busy cases, clear during a push.
    pop_message();
    push_byte(8'hA5);
    push_begin(32'h8000_0000, 6'd0);
    pop_message();
    pop_message();
    push_begin(32'hFFFF_FFFF, 6'd2);
    pop_message();
    push_begin(32'h0000_0000, 6'd63);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h5A);
    pop_message();
    push_begin(32'h7FFF_FFFF, 6'd5);
    push_byte(8'h81);
    push_byte(8'h7E);
    clear_ring();
    push_byte(8'h3C);
    pop_message();
    push_begin(32'h1234_5678, 6'd1);
    push_byte(8'hC3);
    push_begin(32'h0000_0000, 6'd0);
    pop_message();
    pop_message();
    pop_message();

    // Move the pointers off zero before the random phase.
    clear_ring();
    push_begin($urandom(), 6'd3);
    repeat (3) push_byte(8'($urandom()));
    pop_message();
    hold_requests++;

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (!mid_hold && items_sent - random_start > RANDOM_ITEMS / 2) begin
        mid_hold = 1'b1;
        hold_requests++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_message(pick_len());
      end else if (pick < 78) begin
        pop_message();
      end else if (pick < 83) begin
        clear_ring();
      end else if (pick < 88) begin
        push_byte(8'($urandom()));
      end else begin
        // Truncated push, closed only by a clear.
        len = $urandom_range(2, 20);
        push_begin($urandom(), LEN_W'(len));
        repeat ($urandom_range(0, len - 1)) push_byte(8'($urandom()));
        clear_ring();
      end
    end

    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
